@@ src/tlqs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the two-level queue scheduler.
// No dependencies; compiled first.
package tlqs_pkg;

	localparam int MAX_PROCESSES = 16;

	localparam int ARR_W  = 16;
	localparam int BUR_W  = 16;
	localparam int LVL_W  = 2;
	localparam int TIME_W = 21;
	localparam int PNUM_W = 5;
	localparam int QNT_W  = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [QNT_W-1:0] QHIGH_RST = 8'd4;
	localparam logic [QNT_W-1:0] QLOW_RST  = 8'd3;
	localparam logic [LVL_W-1:0] LVL_HIGH  = 2'd1;

	localparam logic [CFG_IDX_W-1:0] CFG_QHIGH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_QLOW  = 1'b1;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_START,
		ST_PICK,
		ST_RUN,
		ST_SCAN,
		ST_POST,
		ST_EMIT,
		ST_JUMP,
		ST_END
	} state_t;

	typedef struct packed {
		logic scan_clr;
		logic step;
		logic load;
		logic start;
		logic pop_high;
		logic pop_low;
		logic run;
		logic scan;
		logic jump;
		logic requeue;
		logic calc;
		logic emit;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic hq_nempty;
		logic lq_nempty;
		logic scan_last;
		logic jump_hit;
		logic cur_has_rem;
		logic done;
		logic out_free;
	} status_t;

endpackage

@@ src/tlqs_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for process loads and completion results.
// Depends on tlqs_pkg for field widths.
interface tlqs_in_if;
	logic                          valid;
	logic                          ready;
	logic [tlqs_pkg::ARR_W-1:0]    arrival_time;
	logic [tlqs_pkg::BUR_W-1:0]    burst_time;
	logic [tlqs_pkg::LVL_W-1:0]    queue_level;
	logic                          last_process;

	modport source (output valid, arrival_time, burst_time, queue_level, last_process,
		input ready);
	modport sink (input valid, arrival_time, burst_time, queue_level, last_process,
		output ready);
endinterface

interface tlqs_out_if;
	logic                          valid;
	logic                          ready;
	logic [tlqs_pkg::PNUM_W-1:0]   process_number;
	logic [tlqs_pkg::TIME_W-1:0]   completion_time;
	logic [tlqs_pkg::TIME_W-1:0]   turnaround;
	logic [tlqs_pkg::TIME_W-1:0]   waiting;
	logic                          last_result;

	modport source (output valid, process_number, completion_time, turnaround, waiting,
		last_result, input ready);
	modport sink (input valid, process_number, completion_time, turnaround, waiting,
		last_result, output ready);
endinterface

@@ src/two_level_queue_scheduler_top.sv @@
`timescale 1ns / 1ps
// Top level of the two-level round-robin queue scheduler.
// Depends on tlqs_pkg, tlqs_if, tlqs_ctrl and tlqs_dp.

// Processes are loaded one transaction per cycle on in_ch and kept sorted by
// arrival (stable). The transaction with last_process set (kept or, on a full
// table, dropped) starts a run: high-level processes always go before low-level
// ones, each queue is FIFO round robin with its own quantum (0 acts as 1), and a
// slice is never cut short. Each completion is one transaction on out_ch, in
// completion order; the final one carries last_result. After the closing load a
// start step runs, then each slice takes a pick, a run, a rescan that walks the
// sorted record table one entry a cycle, and a post step; each idle jump takes a
// pick and the same walk up to a later arrival; each completion takes an emit
// that waits out any stall on out_ch; a closing step ends the run. No loads
// are taken while a run is in progress. Quantum writes on the cfg port belong
// between runs.
module two_level_queue_scheduler_top #(
	parameter int MAX_PROC = tlqs_pkg::MAX_PROCESSES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tlqs_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [tlqs_pkg::QNT_W-1:0]        cfg_wdata,
	tlqs_in_if.sink                           in_ch,
	tlqs_out_if.source                        out_ch
);

	tlqs_pkg::cmd_t    cmd;
	tlqs_pkg::status_t status;

	// sequencer: owns the input handshake
	tlqs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_last  (in_ch.last_process),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// records, queues, sim time and the output register
	tlqs_dp #(
		.MAX_PROC (MAX_PROC)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.arrival_time    (in_ch.arrival_time),
		.burst_time      (in_ch.burst_time),
		.queue_level     (in_ch.queue_level),
		.out_valid       (out_ch.valid),
		.out_ready       (out_ch.ready),
		.process_number  (out_ch.process_number),
		.completion_time (out_ch.completion_time),
		.turnaround      (out_ch.turnaround),
		.waiting         (out_ch.waiting),
		.last_result     (out_ch.last_result)
	);

endmodule

@@ src/tlqs_ctrl.sv @@
`timescale 1ns / 1ps
// Scheduler sequencer: load, slice, rescan, idle jump and emit phases.
// Depends on tlqs_pkg; drives tlqs_dp through cmd_t, reads status_t.
module tlqs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_last,
	output logic               in_ready,
	input  tlqs_pkg::status_t  status,
	output tlqs_pkg::cmd_t     cmd
);

	tlqs_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlqs_pkg::ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			tlqs_pkg::ST_LOAD: begin
				if (in_valid && in_last) state_nxt = tlqs_pkg::ST_START;
			end
			tlqs_pkg::ST_START: state_nxt = tlqs_pkg::ST_PICK;
			tlqs_pkg::ST_PICK: begin
				if (status.hq_nempty || status.lq_nempty) state_nxt = tlqs_pkg::ST_RUN;
				else state_nxt = tlqs_pkg::ST_JUMP;
			end
			tlqs_pkg::ST_RUN: state_nxt = tlqs_pkg::ST_SCAN;
			tlqs_pkg::ST_SCAN: begin
				if (status.scan_last) state_nxt = tlqs_pkg::ST_POST;
			end
			tlqs_pkg::ST_POST: begin
				if (status.cur_has_rem) state_nxt = tlqs_pkg::ST_PICK;
				else state_nxt = tlqs_pkg::ST_EMIT;
			end
			tlqs_pkg::ST_EMIT: begin
				if (status.out_free) begin
					if (status.done) state_nxt = tlqs_pkg::ST_END;
					else state_nxt = tlqs_pkg::ST_PICK;
				end
			end
			tlqs_pkg::ST_JUMP: begin
				if (status.jump_hit) state_nxt = tlqs_pkg::ST_PICK;
				else if (status.scan_last) state_nxt = tlqs_pkg::ST_END;
			end
			tlqs_pkg::ST_END: state_nxt = tlqs_pkg::ST_LOAD;
			default: state_nxt = tlqs_pkg::ST_LOAD;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			tlqs_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				cmd.scan_clr = 1'b1;
			end
			tlqs_pkg::ST_START: cmd.start = 1'b1;
			tlqs_pkg::ST_PICK: begin
				if (status.hq_nempty) cmd.pop_high = 1'b1;
				else if (status.lq_nempty) cmd.pop_low = 1'b1;
				else cmd.scan_clr = 1'b1;
			end
			tlqs_pkg::ST_RUN: begin
				cmd.run = 1'b1;
				cmd.scan_clr = 1'b1;
			end
			tlqs_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				cmd.step = 1'b1;
			end
			tlqs_pkg::ST_POST: begin
				if (status.cur_has_rem) cmd.requeue = 1'b1;
				else cmd.calc = 1'b1;
			end
			tlqs_pkg::ST_EMIT: cmd.emit = status.out_free;
			tlqs_pkg::ST_JUMP: begin
				if (status.jump_hit) cmd.jump = 1'b1;
				else cmd.step = 1'b1;
			end
			tlqs_pkg::ST_END: cmd.clear = 1'b1;
			default: cmd = '0;
		endcase
	end

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> status.out_free)
		else $error("emit while output register busy");
	a_pop_high: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_high |-> status.hq_nempty)
		else $error("pop from empty high queue");
	a_pop_low: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_low |-> (!status.hq_nempty && status.lq_nempty))
		else $error("low queue served ahead of high queue");
	a_run_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run |-> ($past(cmd.pop_high) || $past(cmd.pop_low)))
		else $error("slice without a dequeued process");
`endif

endmodule

@@ src/tlqs_dp.sv @@
`timescale 1ns / 1ps
// Scheduler datapath: sorted process records, two FIFO queues, time and result registers.
// Depends on tlqs_pkg; commanded by tlqs_ctrl.
module tlqs_dp #(
	parameter int MAX_PROC = tlqs_pkg::MAX_PROCESSES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tlqs_pkg::cmd_t                    cmd,
	output tlqs_pkg::status_t                 status,
	input  logic                              cfg_we,
	input  logic [tlqs_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [tlqs_pkg::QNT_W-1:0]        cfg_wdata,
	input  logic [tlqs_pkg::ARR_W-1:0]        arrival_time,
	input  logic [tlqs_pkg::BUR_W-1:0]        burst_time,
	input  logic [tlqs_pkg::LVL_W-1:0]        queue_level,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [tlqs_pkg::PNUM_W-1:0]       process_number,
	output logic [tlqs_pkg::TIME_W-1:0]       completion_time,
	output logic [tlqs_pkg::TIME_W-1:0]       turnaround,
	output logic [tlqs_pkg::TIME_W-1:0]       waiting,
	output logic                              last_result
);

	localparam int IW = (MAX_PROC > 1) ? $clog2(MAX_PROC) : 1;
	localparam int CW = $clog2(MAX_PROC + 1);
	localparam int NW = (CW > tlqs_pkg::PNUM_W) ? CW : tlqs_pkg::PNUM_W;

	typedef struct packed {
		logic [tlqs_pkg::ARR_W-1:0] arr;
		logic [tlqs_pkg::BUR_W-1:0] bur;
		logic                       low;
		logic [IW-1:0]              pid;
	} rec_t;

	// records kept in arrival order (stable)
	rec_t                       rec_q     [MAX_PROC];
	logic [tlqs_pkg::BUR_W-1:0] rem_q     [MAX_PROC];
	rec_t                       rec_prev  [MAX_PROC];
	logic [tlqs_pkg::BUR_W-1:0] rem_prev  [MAX_PROC];
	logic [MAX_PROC-1:0]        rem_nz_q;
	logic [MAX_PROC-1:0]        flag_q;
	logic [MAX_PROC-1:0]        ins, prev_ins, live;
	logic [CW-1:0]              count_q;

	logic [IW-1:0]              hq_q [MAX_PROC];
	logic [IW-1:0]              lq_q [MAX_PROC];
	logic [IW-1:0]              hq_head_q, hq_tail_q, lq_head_q, lq_tail_q;
	logic [CW-1:0]              hq_cnt_q, lq_cnt_q;

	logic [tlqs_pkg::QNT_W-1:0]  qhigh_q, qlow_q, quant_q;
	logic [tlqs_pkg::TIME_W-1:0] time_q;
	logic [IW-1:0]               cur_q, scan_idx_q, rd_idx, enq_id;
	logic [tlqs_pkg::BUR_W-1:0]  cur_rem_q, run_len, rem_next;
	logic [tlqs_pkg::TIME_W-1:0] tat_q;
	logic [tlqs_pkg::BUR_W-1:0]  cbur_q;
	logic [IW-1:0]               cpid_q;
	logic                        done_q;

	rec_t                        rd_rec, new_rec;
	logic [tlqs_pkg::BUR_W-1:0]  rd_rem;
	logic                        rd_flag, scan_hit, enq, load_ok, pop, pop_id_low;
	logic [IW-1:0]               pop_id;
	logic [tlqs_pkg::QNT_W-1:0]  pop_q;
	logic [NW-1:0]               pnum_wide;
	logic [tlqs_pkg::TIME_W-1:0] bur_ext;

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
		if (p == IW'(MAX_PROC - 1)) return '0;
		else return p + IW'(1);
	endfunction

	assign load_ok = cmd.load && (count_q < CW'(MAX_PROC));
	assign new_rec = '{arr: arrival_time, bur: burst_time,
		low: (queue_level != tlqs_pkg::LVL_HIGH), pid: IW'(count_q)};

	// insertion point: first live entry with a strictly later arrival, else the end
	always_comb begin
		for (int k = 0; k < MAX_PROC; k++) begin
			live[k] = CW'(k) < count_q;
			ins[k] = (live[k] && (rec_q[k].arr > arrival_time)) || (CW'(k) == count_q);
		end
		prev_ins[0] = 1'b0;
		rec_prev[0] = rec_q[0];
		rem_prev[0] = rem_q[0];
		for (int k = 1; k < MAX_PROC; k++) begin
			prev_ins[k] = ins[k-1];
			rec_prev[k] = rec_q[k-1];
			rem_prev[k] = rem_q[k-1];
		end
	end

	always_comb begin
		if (cmd.pop_high) rd_idx = hq_q[hq_head_q];
		else if (cmd.pop_low) rd_idx = lq_q[lq_head_q];
		else if (cmd.requeue || cmd.calc) rd_idx = cur_q;
		else rd_idx = scan_idx_q;
	end

	assign rd_rec  = rec_q[rd_idx];
	assign rd_rem  = rem_q[rd_idx];
	assign rd_flag = flag_q[rd_idx];

	assign scan_hit = ({{(tlqs_pkg::TIME_W - tlqs_pkg::ARR_W){1'b0}}, rd_rec.arr} <= time_q)
		&& (scan_idx_q != cur_q) && !rd_flag && (rd_rem != '0);

	assign enq    = cmd.start || cmd.jump || cmd.requeue || (cmd.scan && scan_hit);
	assign enq_id = cmd.requeue ? cur_q : scan_idx_q;
	assign pop    = cmd.pop_high || cmd.pop_low;
	assign pop_id = rd_idx;
	assign pop_id_low = cmd.pop_low;
	assign pop_q  = pop_id_low ? qlow_q : qhigh_q;

	assign run_len  = (cur_rem_q < {{(tlqs_pkg::BUR_W - tlqs_pkg::QNT_W){1'b0}}, quant_q})
		? cur_rem_q : {{(tlqs_pkg::BUR_W - tlqs_pkg::QNT_W){1'b0}}, quant_q};
	assign rem_next = cur_rem_q - run_len;

	// record table: shift-insert on load, remaining work update after a slice
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_PROC; k++) begin
			if (load_ok) begin
				if (prev_ins[k]) begin
					rec_q[k] <= rec_prev[k];
					rem_q[k] <= rem_prev[k];
				end else if (ins[k]) begin
					rec_q[k] <= new_rec;
					rem_q[k] <= burst_time;
				end
			end else if (cmd.run && (cur_q == IW'(k))) begin
				rem_q[k] <= rem_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_nz_q <= '0;
			flag_q   <= '0;
		end else begin
			for (int k = 0; k < MAX_PROC; k++) begin
				if (load_ok) begin
					if (prev_ins[k]) rem_nz_q[k] <= rem_nz_q[(k > 0) ? k - 1 : 0];
					else if (ins[k]) rem_nz_q[k] <= (burst_time != '0);
				end else if (cmd.run && (cur_q == IW'(k))) begin
					rem_nz_q[k] <= (rem_next != '0);
				end
				if (cmd.clear) flag_q[k] <= 1'b0;
				else if (enq && (enq_id == IW'(k))) flag_q[k] <= 1'b1;
				else if (pop && (pop_id == IW'(k))) flag_q[k] <= 1'b0;
			end
		end
	end

	// queue storage: written at tail, read at head
	always_ff @(posedge clk) begin
		if (enq && !rd_rec.low) hq_q[hq_tail_q] <= enq_id;
		if (enq && rd_rec.low) lq_q[lq_tail_q] <= enq_id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hq_head_q <= '0;
			hq_tail_q <= '0;
			hq_cnt_q  <= '0;
			lq_head_q <= '0;
			lq_tail_q <= '0;
			lq_cnt_q  <= '0;
			count_q   <= '0;
			qhigh_q   <= tlqs_pkg::QHIGH_RST;
			qlow_q    <= tlqs_pkg::QLOW_RST;
			time_q    <= '0;
			scan_idx_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					tlqs_pkg::CFG_QHIGH: qhigh_q <= cfg_wdata;
					tlqs_pkg::CFG_QLOW:  qlow_q <= cfg_wdata;
					default: qhigh_q <= qhigh_q;
				endcase
			end
			if (cmd.clear) begin
				hq_head_q <= '0;
				hq_tail_q <= '0;
				hq_cnt_q  <= '0;
				lq_head_q <= '0;
				lq_tail_q <= '0;
				lq_cnt_q  <= '0;
				count_q   <= '0;
			end else begin
				if (load_ok) count_q <= count_q + CW'(1);
				if (enq && !rd_rec.low) begin
					hq_tail_q <= wrap_inc(hq_tail_q);
					hq_cnt_q  <= hq_cnt_q + CW'(1);
				end
				if (enq && rd_rec.low) begin
					lq_tail_q <= wrap_inc(lq_tail_q);
					lq_cnt_q  <= lq_cnt_q + CW'(1);
				end
				if (cmd.pop_high) begin
					hq_head_q <= wrap_inc(hq_head_q);
					hq_cnt_q  <= hq_cnt_q - CW'(1);
				end
				if (cmd.pop_low) begin
					lq_head_q <= wrap_inc(lq_head_q);
					lq_cnt_q  <= lq_cnt_q - CW'(1);
				end
			end
			if (cmd.start || cmd.jump) begin
				time_q <= tlqs_pkg::TIME_W'(rd_rec.arr);
			end else if (cmd.run) begin
				time_q <= time_q + tlqs_pkg::TIME_W'(run_len);
			end
			if (cmd.scan_clr) scan_idx_q <= '0;
			else if (cmd.step) scan_idx_q <= scan_idx_q + IW'(1);
			if (cmd.emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// current process and completion payload
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q     <= pop_id;
			cur_rem_q <= rd_rem;
			quant_q   <= (pop_q == '0) ? tlqs_pkg::QNT_W'(1) : pop_q;
		end else if (cmd.run) begin
			cur_rem_q <= rem_next;
		end
		if (cmd.calc) begin
			tat_q  <= time_q - tlqs_pkg::TIME_W'(rd_rec.arr);
			cbur_q <= rd_rec.bur;
			cpid_q <= rd_rec.pid;
			done_q <= ~|(rem_nz_q & live);
		end
		if (cmd.emit) begin
			process_number  <= pnum_wide[tlqs_pkg::PNUM_W-1:0];
			completion_time <= time_q;
			turnaround      <= tat_q;
			waiting         <= (tat_q >= bur_ext) ? (tat_q - bur_ext) : '0;
			last_result     <= done_q;
		end
	end

	assign bur_ext   = tlqs_pkg::TIME_W'(cbur_q);
	assign pnum_wide = NW'(cpid_q) + NW'(1);

	always_comb begin
		status = '0;
		status.hq_nempty   = hq_cnt_q != '0;
		status.lq_nempty   = lq_cnt_q != '0;
		status.scan_last   = CW'(scan_idx_q) == (count_q - CW'(1));
		status.jump_hit    = {{(tlqs_pkg::TIME_W - tlqs_pkg::ARR_W){1'b0}}, rd_rec.arr} > time_q;
		status.cur_has_rem = cur_rem_q != '0;
		status.done        = done_q;
		status.out_free    = !out_valid || out_ready;
	end

endmodule
